[rtl/core/rcfa_pkg.sv]
// Shared types and constants for the report chunk frame assembler.
`default_nettype none
package rcfa_pkg;

    localparam int REPORT_BYTES = 64;
    localparam int IDX_W        = $clog2(REPORT_BYTES);
    localparam logic [6:0] CAP_MAX  = 7'(REPORT_BYTES);
    localparam logic [5:0] HDR_MIN  = 6'd8;
    localparam logic [9:0] LEN_MASK = 10'h3FF;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_HEADER_BYTES = 3'd2,
        REG_CAPACITY     = 3'd3,
        REG_REPORT_ID    = 3'd4,
        REG_ECHO         = 3'd5,
        REG_COMMAND      = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_WRITTEN  = 4'd0,
        ST_SHORT    = 4'd1,
        ST_ID       = 4'd2,
        ST_ECHO     = 4'd3,
        ST_COMMAND  = 4'd4,
        ST_CHECKSUM = 4'd5,
        ST_LENGTH   = 4'd6,
        ST_EMPTY    = 4'd7,
        ST_OUTSIDE  = 4'd8
    } status_t;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_START    = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] byte_value;
        logic       end_of_report;
    } in_item_t;

    typedef struct packed {
        logic        item_kind;
        logic [24:0] write_address;
        logic [7:0]  write_data;
        logic [3:0]  report_status;
        logic [24:0] bytes_covered;
        logic        frame_done;
        logic [31:0] packet_total;
        logic        last_result;
    } out_item_t;

endpackage
`default_nettype wire

[rtl/core/rcfa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rcfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/core/report_chunk_frame_assembler.sv]
// Report chunk frame assembler: buffers report bytes, checks them, emits frame writes.
//
// Bytes are taken one per cycle while the block is idle and stored in a 64-entry report RAM.
// After the final byte the block checks the header, then reads the four address bytes from
// the RAM, each through a request and a capture state, and for a chunk that fits in the frame
// emits one write transaction per payload byte, each again through a request and a capture
// state because the RAM read is registered; the status transaction follows. The input stays
// closed from the last byte until the status transaction is issued, longer under an output
// stall. A start operation clears the frame progress and packet count and gives no result.
`default_nettype none
module report_chunk_frame_assembler (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rcfa_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rcfa_pkg::out_item_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [11:0]         cfg_data
);
    import rcfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_AREQ, S_ACAP, S_EVAL, S_DREQ, S_DCAP, S_STAT
    } state_t;

    state_t      state_reg, state_next;
    logic [11:0] width_reg, width_next, height_reg, height_next;
    logic [5:0]  hb_reg, hb_next;
    logic [6:0]  rc_reg, rc_next;
    logic [7:0]  id_reg, id_next, echo_reg, echo_next, cmd_reg, cmd_next;
    logic [24:0] fs_reg, fs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        ov_reg, ov_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hb_byte_reg [7];
    logic [7:0]  hb_byte_next [7];
    logic [32:0] far_reg, far_next;
    logic [31:0] pkts_reg, pkts_next;
    logic        was_done_reg, was_done_next;
    logic [3:0]  status_reg, status_next;
    logic [5:0]  len_reg, len_next;
    logic [5:0]  ptr_reg, ptr_next;
    logic [1:0]  k_reg, k_next;
    logic [5:0]  i_reg, i_next;
    logic [31:0] addr_reg, addr_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_rdata;

    logic [6:0]  cap;
    logic [5:0]  hdr;
    logic [10:0] data_end;
    logic [10:0] hdr_w;
    logic [10:0] len_w;
    logic [32:0] chunk_end;
    logic        out_free;
    logic        frame_done_now;

    rcfa_ram #(.WIDTH(8), .DEPTH(REPORT_BYTES)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (in_data.byte_value),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign cap       = (rc_reg > CAP_MAX) ? CAP_MAX : rc_reg;
    assign hdr       = (hb_reg < HDR_MIN) ? HDR_MIN : hb_reg;
    assign hdr_w     = {5'd0, hdr};
    assign data_end  = {1'b0, {hb_byte_reg[5][1:0], hb_byte_reg[4]} & LEN_MASK} + 11'd4;
    assign len_w     = data_end - hdr_w - 11'd4;
    assign chunk_end = {1'b0, addr_reg} + {27'd0, len_reg};
    assign out_free  = !out_valid_reg || out_ready;
    assign mem_waddr = cnt_reg[IDX_W-1:0];
    assign frame_done_now = (far_reg >= {8'd0, fs_reg});

    always_comb
    begin
        state_next    = state_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        hb_next       = hb_reg;
        rc_next       = rc_reg;
        id_next       = id_reg;
        echo_next     = echo_reg;
        cmd_next      = cmd_reg;
        fs_next       = {24'(width_reg) * 24'(height_reg), 1'b0};
        cnt_next      = cnt_reg;
        ov_next       = ov_reg;
        sum_next      = sum_reg;
        hb_byte_next  = hb_byte_reg;
        far_next      = far_reg;
        pkts_next     = pkts_reg;
        was_done_next = was_done_reg;
        status_next   = status_reg;
        len_next      = len_reg;
        ptr_next      = ptr_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        addr_next     = addr_reg;
        out_next      = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we        = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = cfg_data;
                REG_FRAME_HEIGHT: height_next = cfg_data;
                REG_HEADER_BYTES: hb_next     = cfg_data[5:0];
                REG_CAPACITY:     rc_next     = cfg_data[6:0];
                REG_REPORT_ID:    id_next     = cfg_data[7:0];
                REG_ECHO:         echo_next   = cfg_data[7:0];
                REG_COMMAND:      cmd_next    = cfg_data[7:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.operation == OP_START)
                    begin
                        cnt_next  = '0;
                        ov_next   = 1'b0;
                        sum_next  = '0;
                        far_next  = '0;
                        pkts_next = '0;
                    end
                    else
                    begin
                        if (cnt_reg < cap)
                        begin
                            mem_we = 1'b1;
                            for (int b = 0; b < 7; b++)
                            begin
                                if (cnt_reg == 7'(b))
                                begin
                                    hb_byte_next[b] = in_data.byte_value;
                                end
                            end
                            // checksum bytes count as zero
                            if (cnt_reg != 7'd2 && cnt_reg != 7'd3)
                            begin
                                sum_next = sum_reg + (cnt_reg[0] ?
                                    {in_data.byte_value, 8'd0} : {8'd0, in_data.byte_value});
                            end
                            cnt_next = cnt_reg + 7'd1;
                        end
                        else
                        begin
                            ov_next = 1'b1;
                        end
                        if (in_data.end_of_report)
                        begin
                            state_next = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                was_done_next = frame_done_now;
                state_next    = S_STAT;
                ptr_next      = hdr;
                k_next        = '0;
                len_next      = len_w[5:0];
                priority if (ov_reg)
                    status_next = ST_LENGTH;
                else if (cnt_reg < {1'b0, hdr})
                    status_next = ST_SHORT;
                else if (hb_byte_reg[0] != id_reg)
                    status_next = ST_ID;
                else if (hb_byte_reg[1] != echo_reg && hb_byte_reg[1] != 8'd0)
                    status_next = ST_ECHO;
                else if (hb_byte_reg[6] != cmd_reg)
                    status_next = ST_COMMAND;
                else if ({hb_byte_reg[3], hb_byte_reg[2]} != sum_reg)
                    status_next = ST_CHECKSUM;
                else
                begin
                    pkts_next = pkts_reg + 32'd1;
                    priority if (data_end <= hdr_w || data_end > {4'd0, cap}
                                 || data_end < hdr_w + 11'd4)
                        status_next = ST_LENGTH;
                    else if (data_end == hdr_w + 11'd4)
                        status_next = ST_EMPTY;
                    else
                        state_next = S_AREQ;
                end
            end
            S_AREQ:
            begin
                ptr_next   = ptr_reg + 6'd1;
                state_next = S_ACAP;
            end
            S_ACAP:
            begin
                addr_next = {mem_rdata, addr_reg[31:8]};
                k_next    = k_reg + 2'd1;
                state_next = (k_reg == 2'd3) ? S_EVAL : S_AREQ;
            end
            S_EVAL:
            begin
                i_next = '0;
                if (chunk_end <= {8'd0, fs_reg})
                begin
                    status_next = ST_WRITTEN;
                    state_next  = S_DREQ;
                end
                else
                begin
                    status_next = ST_OUTSIDE;
                    state_next  = S_STAT;
                end
                if (chunk_end > far_reg)
                begin
                    far_next = chunk_end;
                end
            end
            S_DREQ:
            begin
                if (out_free)
                begin
                    ptr_next   = ptr_reg + 6'd1;
                    state_next = S_DCAP;
                end
            end
            S_DCAP:
            begin
                out_next       = '0;
                out_next.item_kind     = KIND_WRITE;
                out_next.write_address = addr_reg[24:0] + {19'd0, i_reg};
                out_next.write_data    = mem_rdata;
                out_valid_next = 1'b1;
                i_next         = i_reg + 6'd1;
                state_next     = (i_reg + 6'd1 == len_reg) ? S_STAT : S_DREQ;
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    out_next = '0;
                    out_next.item_kind     = KIND_STATUS;
                    out_next.report_status = status_reg;
                    out_next.bytes_covered = frame_done_now ? fs_reg : far_reg[24:0];
                    out_next.frame_done    = frame_done_now;
                    out_next.packet_total  = pkts_reg;
                    out_next.last_result   = !was_done_reg && frame_done_now;
                    out_valid_next = 1'b1;
                    cnt_next   = '0;
                    ov_next    = 1'b0;
                    sum_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= 12'd240;
            height_reg    <= 12'd240;
            hb_reg        <= 6'd8;
            rc_reg        <= 7'd64;
            id_reg        <= 8'd34;
            echo_reg      <= 8'd0;
            cmd_reg       <= 8'd0;
            fs_reg        <= 25'd115200;
            cnt_reg       <= '0;
            ov_reg        <= 1'b0;
            sum_reg       <= '0;
            far_reg       <= '0;
            pkts_reg      <= '0;
            was_done_reg  <= 1'b0;
            status_reg    <= '0;
            len_reg       <= '0;
            ptr_reg       <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            hb_reg        <= hb_next;
            rc_reg        <= rc_next;
            id_reg        <= id_next;
            echo_reg      <= echo_next;
            cmd_reg       <= cmd_next;
            fs_reg        <= fs_next;
            cnt_reg       <= cnt_next;
            ov_reg        <= ov_next;
            sum_reg       <= sum_next;
            far_reg       <= far_next;
            pkts_reg      <= pkts_next;
            was_done_reg  <= was_done_next;
            status_reg    <= status_next;
            len_reg       <= len_next;
            ptr_reg       <= ptr_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hb_byte_reg <= hb_byte_next;
        addr_reg    <= addr_next;
        out_reg     <= out_next;
    end
endmodule
`default_nettype wire

[rtl/core/rcfa_checker.sv]
// Port-level checker for the report chunk frame assembler, with its bind.
`default_nettype none
module rcfa_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire rcfa_pkg::in_item_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire rcfa_pkg::out_item_t out_data
);
    import rcfa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.operation == OP_BYTE && in_data.end_of_report
        |=> !in_ready)
        else $error("input still open right after a report end");

    a_last_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_result |-> out_data.item_kind == KIND_STATUS
        && out_data.frame_done)
        else $error("last_result without a completed frame");

    a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.item_kind == KIND_WRITE |-> out_data.report_status == ST_WRITTEN
        && out_data.packet_total == 32'd0 && !out_data.frame_done)
        else $error("write transaction carries status fields");
endmodule

bind report_chunk_frame_assembler rcfa_checker u_rcfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

[tb/report_chunk_frame_assembler_test.sv]
// Self-checking testbench for the report chunk frame assembler.
`timescale 1ns / 1ps
`default_nettype none
module report_chunk_frame_assembler_test;
    import rcfa_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [11:0] cfg_data = '0;

    report_chunk_frame_assembler u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mirror of the block's registers and state
    logic [11:0] m_width, m_height;
    logic [5:0] m_hdr;
    logic [6:0] m_cap;
    logic [7:0] m_id, m_echo, m_cmd;
    logic [7:0] m_store [64];
    int unsigned m_rcv;
    bit m_over;
    logic [15:0] m_sum;
    longint unsigned m_furthest;
    logic [31:0] m_packets;

    in_item_t pending_bytes[$];
    out_item_t expected_items[$];

    int send_idle_pct, recv_idle_pct;
    bit recv_hold;
    bit hold_go = 1'b0;
    bit hold_done;
    int fail_count, accepted_in, results_seen, writes_seen, quiet_cycles;
    int status_seen [9];
    bit accepted_flag = 1'b0;

    // rebuilds the expected transactions for one accepted input
    task automatic predict_item(input in_item_t it);
        int unsigned cap, hdr, data_end, data_len, status, idx;
        longint unsigned fsize, addr, last_end;
        logic [15:0] v;
        bit was_done, now_done;
        out_item_t o;
        if (it.operation == OP_START)
        begin
            m_rcv = 0; m_over = 0; m_sum = '0; m_furthest = 0; m_packets = '0;
            return;
        end
        cap = (m_cap > 64) ? 64 : m_cap;
        if (m_rcv < cap)
        begin
            idx = m_rcv;
            m_store[idx] = it.byte_value;
            v = {8'h00, it.byte_value};
            if (idx != 2 && idx != 3)
                m_sum = m_sum + ((idx & 1) ? (v << 8) : v);
            m_rcv++;
        end
        else
            m_over = 1;
        if (!it.end_of_report)
            return;
        fsize = longint'(m_width) * longint'(m_height) * 2;
        was_done = m_furthest >= fsize;
        hdr = (m_hdr < 8) ? 8 : m_hdr;
        if (m_over) status = ST_LENGTH;
        else if (m_rcv < hdr) status = ST_SHORT;
        else if (m_store[0] != m_id) status = ST_ID;
        else if (m_store[1] != m_echo && m_store[1] != 8'h00) status = ST_ECHO;
        else if (m_store[6] != m_cmd) status = ST_COMMAND;
        else if ({m_store[3], m_store[2]} != m_sum) status = ST_CHECKSUM;
        else
        begin
            m_packets++;
            data_end = ({m_store[5], m_store[4]} & 16'h03FF) + 4;
            if (data_end <= hdr || data_end > cap || data_end - hdr < 4) status = ST_LENGTH;
            else
            begin
                data_len = data_end - hdr - 4;
                if (data_len == 0) status = ST_EMPTY;
                else
                begin
                    addr = {m_store[(hdr + 3) % 64], m_store[(hdr + 2) % 64],
                            m_store[(hdr + 1) % 64], m_store[hdr % 64]};
                    last_end = addr + data_len;
                    if (last_end <= fsize)
                    begin
                        for (int i = 0; i < data_len; i++)
                        begin
                            o = '0;
                            o.item_kind = KIND_WRITE;
                            o.write_address = 25'(addr + i);
                            o.write_data = m_store[(hdr + 4 + i) % 64];
                            expected_items.push_back(o);
                        end
                        status = ST_WRITTEN;
                    end
                    else
                        status = ST_OUTSIDE;
                    if (last_end > m_furthest) m_furthest = last_end;
                end
            end
        end
        now_done = m_furthest >= fsize;
        o = '0;
        o.item_kind = KIND_STATUS;
        o.report_status = 4'(status);
        o.bytes_covered = 25'((m_furthest < fsize) ? m_furthest : fsize);
        o.frame_done = now_done;
        o.packet_total = m_packets;
        o.last_result = !was_done && now_done;
        expected_items.push_back(o);
        m_rcv = 0; m_over = 0; m_sum = '0;
    endtask

    // driver: offers queued bytes, changes at the falling edge
    always @(negedge clk)
    begin
        if (!in_valid || accepted_flag)
        begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data <= pending_bytes.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // receiver stall: holds off for a counted stretch once requested
    initial
    begin
        recv_hold = 1'b0;
        hold_done = 1'b0;
        wait (hold_go);
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold = 1'b0;
        hold_done = 1'b1;
    end

    // monitor: samples both handshakes at the rising edge
    always @(posedge clk)
    begin
        accepted_flag <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (in_valid && in_ready)
            begin
                predict_item(in_data);
                accepted_in <= accepted_in + 1;
            end
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_items.size() == 0)
                begin
                    $display("%0t: unexpected transaction %p", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    out_item_t e;
                    e = expected_items.pop_front();
                    if (e.item_kind == KIND_STATUS)
                        status_seen[e.report_status]++;
                    else
                        writes_seen <= writes_seen + 1;
                    if (out_data !== e)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (quiet_cycles > QUIET_LIMIT)
            begin
                $display("%0t: watchdog, no transaction in %0d cycles", $time, QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_index_t r, input int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= 12'(val);
        case (r)
            REG_FRAME_WIDTH: m_width = 12'(val);
            REG_FRAME_HEIGHT: m_height = 12'(val);
            REG_HEADER_BYTES: m_hdr = 6'(val);
            REG_CAPACITY: m_cap = 7'(val);
            REG_REPORT_ID: m_id = 8'(val);
            REG_ECHO: m_echo = 8'(val);
            default: m_cmd = 8'(val);
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || in_valid || expected_items.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic push_start();
        in_item_t it;
        it = '0;
        it.operation = OP_START;
        pending_bytes.push_back(it);
    endtask

    // queues one report; rpt holds all bytes, the last is marked end
    task automatic push_report(input logic [7:0] rpt [$]);
        in_item_t it;
        foreach (rpt[i])
        begin
            it = '0;
            it.operation = OP_BYTE;
            it.byte_value = rpt[i];
            it.end_of_report = (i == rpt.size() - 1);
            pending_bytes.push_back(it);
        end
    endtask

    // builds a well formed chunk report; mode flips one check to fail
    task automatic push_chunk(input int unsigned plen, input longint unsigned addr,
                              input int mode);
        logic [7:0] r [$];
        int unsigned hdr, n, len;
        logic [15:0] s;
        hdr = (m_hdr < 8) ? 8 : m_hdr;
        len = hdr + 4 + plen - 4;
        n = hdr + 4 + plen;
        r = {};
        for (int i = 0; i < n; i++)
            r.push_back(8'($urandom));
        r[0] = m_id;
        r[1] = $urandom_range(1) ? m_echo : 8'h00;
        r[4] = len[7:0];
        r[5] = {$urandom_range(63) == 0 ? 6'($urandom) : 6'd0, len[9:8]};
        r[6] = m_cmd;
        for (int i = 0; i < 4; i++)
            r[hdr + i] = 8'(addr >> (8 * i));
        case (mode)
            1: r[0] = r[0] ^ 8'(1 << $urandom_range(7));
            2: if (m_echo != 8'hFF) r[1] = 8'hFF; else r[1] = 8'hFE;
            3: r[6] = r[6] ^ 8'h80;
            5: r[4] = 8'($urandom_range(3));
            default: ;
        endcase
        s = '0;
        for (int i = 0; i < n; i++)
            if (i != 2 && i != 3)
                s = s + ((i & 1) ? {r[i], 8'h00} : {8'h00, r[i]});
        if (mode == 4) s = s ^ 16'(1 << $urandom_range(15));
        r[2] = s[7:0];
        r[3] = s[15:8];
        if (mode == 6)
            r = r[0:$urandom_range(hdr - 1)];
        if (mode == 7)
            repeat ($urandom_range(1, 3)) r.push_back(8'($urandom));
        push_report(r);
    endtask

    task automatic random_phase(input int count);
        int unsigned hdr, cap, maxp, plen;
        longint unsigned fsize, addr;
        logic [7:0] noise [$];
        hdr = (m_hdr < 8) ? 8 : m_hdr;
        cap = (m_cap > 64) ? 64 : m_cap;
        maxp = (cap > hdr + 4) ? cap - hdr - 4 : 0;
        fsize = longint'(m_width) * longint'(m_height) * 2;
        while (count > 0)
        begin
            plen = (maxp == 0) ? 0 : $urandom_range(maxp);
            case ($urandom_range(9))
                0: addr = 64'($urandom);
                1: addr = (fsize > plen) ? fsize - plen : 0;
                default: addr = (fsize > plen + 1) ? $urandom_range(fsize - plen) : 0;
            endcase
            if ($urandom_range(15) == 0)
            begin
                noise = {};
                repeat ($urandom_range(1, 12)) noise.push_back(8'($urandom));
                push_report(noise);
                count -= noise.size();
            end
            else if ($urandom_range(40) == 0)
            begin
                push_start();
                count--;
            end
            else
            begin
                push_chunk(plen, addr, ($urandom_range(4) == 0) ? $urandom_range(1, 7) : 0);
                count -= hdr + plen + 4;
            end
        end
    endtask

    initial
    begin
        m_width = 12'd240; m_height = 12'd240; m_hdr = 6'd8; m_cap = 7'd64;
        m_id = 8'd34; m_echo = 8'd0; m_cmd = 8'd0;
        m_rcv = 0; m_over = 0; m_sum = '0; m_furthest = 0; m_packets = '0;
        send_idle_pct = 26; recv_idle_pct = 50;
        fail_count = 0; accepted_in = 0; results_seen = 0; writes_seen = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: small frame, every status, extremes of the byte field
        write_reg(REG_FRAME_WIDTH, 4);
        write_reg(REG_FRAME_HEIGHT, 2);
        write_reg(REG_ECHO, 8'hA5);
        write_reg(REG_COMMAND, 8'hFF);
        push_chunk(2, 0, 0);
        push_chunk(3, 13, 0);
        push_chunk(1, 15, 0);
        push_chunk(1, 0, 1);
        push_chunk(1, 0, 2);
        push_chunk(1, 0, 3);
        push_chunk(1, 0, 4);
        push_chunk(1, 0, 5);
        push_chunk(0, 0, 0);
        push_chunk(1, 0, 6);
        push_chunk(1, 0, 7);
        push_start();
        push_chunk(4, 32'hFFFF_FFFF, 0);
        wait_drained();

        // block fills while the receiver holds off
        write_reg(REG_FRAME_WIDTH, 4095);
        write_reg(REG_FRAME_HEIGHT, 4095);
        write_reg(REG_HEADER_BYTES, 32);
        write_reg(REG_REPORT_ID, 8'hFF);
        hold_go = 1'b1;
        push_chunk(28, 25'h1FF_FF00, 0);
        push_chunk(28, 0, 0);
        wait (hold_done);
        random_phase(60);
        wait_drained();

        send_idle_pct = 50; recv_idle_pct = 26;
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 8);
        write_reg(REG_HEADER_BYTES, 8);
        write_reg(REG_CAPACITY, 13);
        write_reg(REG_REPORT_ID, 0);
        write_reg(REG_ECHO, 0);
        write_reg(REG_COMMAND, 8'h5A);
        random_phase(60);
        wait_drained();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(REG_FRAME_WIDTH, 40);
        write_reg(REG_FRAME_HEIGHT, 3);
        write_reg(REG_HEADER_BYTES, 12);
        write_reg(REG_CAPACITY, 40);
        write_reg(REG_REPORT_ID, 34);
        write_reg(REG_ECHO, 8'h3C);
        random_phase(70);
        wait_drained();

        $display("Run covered %0d input bytes, %0d results, %0d frame writes.",
                 accepted_in, results_seen, writes_seen);
        $display("Status counts written..outside: %p", status_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
rtl/core/rcfa_pkg.sv
rtl/core/rcfa_ram.sv
rtl/core/report_chunk_frame_assembler.sv
rtl/core/rcfa_checker.sv
tb/report_chunk_frame_assembler_test.sv
